### hw/rtl/ibcl_pkg.sv
package ibcl_pkg;

    localparam int CH_N       = 6;
    localparam int CH_W       = 3;
    localparam int ACCEL_N    = 3;
    localparam int RAW_W      = 16;
    localparam int ACC_OUT_W  = 20;
    localparam int GYR_OUT_W  = 26;
    localparam int SUM_W      = 24;
    localparam int BIAS_W     = 26;
    localparam int FILT_W     = 26;
    localparam int CNT_W      = 8;
    localparam int NUM_W      = 32;
    localparam int C_W        = 27;
    localparam int V_W        = 29;
    localparam int D_W        = 30;
    localparam int MB_W       = 18;
    localparam int P_W        = 48;
    localparam int FRAC_SH    = 16;
    localparam int ACC_SH     = 6;
    localparam int Q8_SH      = 8;

    localparam int ALPHA_W    = 17;
    localparam int GAXIS_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 144;

    localparam int CAL_SAMPLES_DEF = 200;

    localparam logic [ALPHA_W-1:0] ALPHA_RST   = 17'd19661;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX   = 17'd65536;
    localparam logic [BIAS_W-1:0]  GRAVITY_Q8  = 26'd4194304;
    localparam logic signed [MB_W-1:0] GYRO_SCALE = 18'sd128070;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAXIS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GNEG  = 2'd2;

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_ACC       = 10'b00_0000_0010,
        ST_DIV_START = 10'b00_0000_0100,
        ST_DIV_WAIT  = 10'b00_0000_1000,
        ST_CORR      = 10'b00_0001_0000,
        ST_SCALE     = 10'b00_0010_0000,
        ST_DELTA     = 10'b00_0100_0000,
        ST_MULA      = 10'b00_1000_0000,
        ST_UPD       = 10'b01_0000_0000,
        ST_EMIT      = 10'b10_0000_0000
    } state_t;

endpackage

### hw/rtl/ibcl_div.sv
module ibcl_div #(
    parameter int DIVISOR = ibcl_pkg::CAL_SAMPLES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ibcl_pkg::NUM_W-1:0]  num,
    output logic                        done,
    output logic [ibcl_pkg::NUM_W-1:0]  quo
);
    import ibcl_pkg::*;

    localparam int DIG_W = 8;
    localparam int T_W   = 2 * DIG_W;
    localparam int DIG_N = NUM_W / DIG_W;
    localparam int IT_W  = $clog2(DIG_N);
    localparam int SH    = T_W + $clog2(DIVISOR);
    localparam int RCP_W = T_W + 1;
    localparam int PR_W  = T_W + RCP_W;
    localparam longint RCP = ((longint'(1) << SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
    localparam logic [RCP_W-1:0] RCP_V   = RCP_W'(RCP);
    localparam logic [DIG_W-1:0] DIV_V   = DIG_W'(DIVISOR);
    localparam logic [IT_W-1:0]  IT_LAST = IT_W'(DIG_N - 1);

    logic [DIG_W-1:0] rem_reg;
    logic [NUM_W-1:0] dvd_reg;
    logic [DIG_W-1:0] qd_reg;
    logic [IT_W-1:0]  it_reg;
    logic             ph_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [T_W-1:0]   trial;
    logic [PR_W-1:0]  prod;
    logic [DIG_W-1:0] qd_calc;
    logic [T_W-1:0]   rem_calc;

    // long division one byte at a time, digit by reciprocal multiplication
    assign trial    = {rem_reg, dvd_reg[NUM_W-1 -: DIG_W]};
    assign prod     = PR_W'(trial) * PR_W'(RCP_V);
    assign qd_calc  = prod[SH +: DIG_W];
    assign rem_calc = trial - T_W'(qd_reg) * T_W'(DIV_V);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
            ph_reg   <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                it_reg   <= '0;
                ph_reg   <= 1'b0;
            end else if (busy_reg) begin
                ph_reg <= ~ph_reg;
                if (ph_reg) begin
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == IT_LAST) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvd_reg <= num;
        end else if (busy_reg) begin
            if (!ph_reg) begin
                qd_reg <= qd_calc;
            end else begin
                rem_reg <= rem_calc[DIG_W-1:0];
                dvd_reg <= {dvd_reg[NUM_W-DIG_W-1:0], qd_reg};
            end
        end
    end

    assign done = done_reg;
    assign quo  = dvd_reg;

endmodule

### hw/rtl/imu_bias_calibrate_lowpass_core.sv
// IMU bias calibration and low-pass filter.
// s_ channel takes one sample per transfer (six raw counts); m_ channel gives one
// filtered result per sample once calibration is over.
// After reset the first CAL_SAMPLES samples are only summed and give no result.
// The last of them then forms six biases with a divider by CAL_SAMPLES that finds
// one quotient byte at a time by reciprocal multiplication, a digit estimate and then
// a remainder update per byte; s_tready is low while it divides.
// A later sample is processed through correction, delta, alpha multiply and update
// steps, with a gyro scale step before the delta for gyroscope channels; the first
// sample, which seeds the filter, skips the alpha multiply. One shared 30x18
// multiplier and two subtractors are stepped over the six channels in turn. A new
// sample is taken only after the last result has gone to the output register.
// s_tready is high only while the sequencer is idle; the next sample is taken
// while a finished result still waits in the output register.
// If the receiver stalls, the sequencer holds its finished result until the output
// register is free; nothing is dropped.
// Reset clears the calibration, the filter and the configuration registers.
// The user writes the configuration port only while idle; the block does not check.
module imu_bias_calibrate_lowpass_core #(
    parameter int CAL_SAMPLES = ibcl_pkg::CAL_SAMPLES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
    input  logic [ibcl_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // accel_x_g, accel_y_g, accel_z_g, gyro_x_dps, gyro_y_dps, gyro_z_dps, zero pad
    output logic [ibcl_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [ibcl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ibcl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import ibcl_pkg::*;

    localparam logic [NUM_W-1:0] HALF_V  = NUM_W'(CAL_SAMPLES / 2);
    localparam logic [CNT_W:0]   CAL_V   = (CNT_W + 1)'(CAL_SAMPLES);
    localparam logic [CH_W-1:0]  CH_LAST = CH_W'(CH_N - 1);
    localparam logic [CH_W-1:0]  CH_ACC  = CH_W'(ACCEL_N);

    state_t state_reg;
    logic [CH_W-1:0] ch_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W:0]   cnt_next;
    logic cal_done_reg;
    logic seeded_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [GAXIS_W-1:0] gaxis_reg;
    logic gneg_reg;
    logic m_tvalid_reg;

    logic signed [RAW_W-1:0]  x_reg    [CH_N];
    logic signed [SUM_W-1:0]  sum_reg  [CH_N];
    logic signed [BIAS_W-1:0] bias_reg [CH_N];
    logic signed [FILT_W-1:0] filt_reg [CH_N];
    logic signed [C_W-1:0]    c_reg;
    logic signed [V_W-1:0]    v_reg;
    logic signed [D_W-1:0]    d_reg;
    logic signed [P_W-1:0]    prod_reg;
    logic                     neg_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;

    logic signed [RAW_W-1:0]  x_cur;
    logic signed [SUM_W-1:0]  sum_cur;
    logic signed [BIAS_W-1:0] bias_cur;
    logic signed [FILT_W-1:0] f_cur;
    logic                     is_accel;
    logic [SUM_W-1:0]         sum_mag;
    logic [NUM_W-1:0]         div_num;
    logic                     div_start;
    logic                     div_done;
    logic [NUM_W-1:0]         div_quo;
    logic [BIAS_W-1:0]        q_mag;
    logic [BIAS_W-1:0]        bias_base;
    logic [BIAS_W-1:0]        bias_new;
    logic signed [C_W-1:0]    c_calc;
    logic signed [V_W-1:0]    v_cur;
    logic signed [D_W-1:0]    d_calc;
    logic [ALPHA_W-1:0]       alpha_sat;
    logic signed [D_W-1:0]    mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [P_W-1:0]    prod_calc;
    logic [FILT_W-1:0]        f_upd;
    logic                     in_xfer;
    logic                     out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    assign x_cur    = x_reg[ch_reg];
    assign sum_cur  = sum_reg[ch_reg];
    assign bias_cur = bias_reg[ch_reg];
    assign f_cur    = filt_reg[ch_reg];
    assign is_accel = ch_reg < CH_ACC;
    assign cnt_next = {1'b0, cnt_reg} + 1'b1;

    // rounding numerator |sum|*256 + N/2
    assign sum_mag   = sum_cur[SUM_W-1] ? SUM_W'(-sum_cur) : SUM_W'(sum_cur);
    assign div_num   = {sum_mag, {Q8_SH{1'b0}}} + HALF_V;
    assign div_start = (state_reg == ST_DIV_START);

    ibcl_div #(
        .DIVISOR (CAL_SAMPLES)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_comb begin
        q_mag     = div_quo[BIAS_W-1:0];
        bias_base = neg_reg ? (~q_mag + 1'b1) : q_mag;
        bias_new  = bias_base;
        if (is_accel && ch_reg == {1'b0, gaxis_reg}) begin
            bias_new = gneg_reg ? bias_base + GRAVITY_Q8 : bias_base - GRAVITY_Q8;
        end
    end

    assign c_calc = (C_W'(x_cur) <<< Q8_SH) - C_W'(bias_cur);
    assign v_cur  = is_accel ? V_W'(c_reg >>> ACC_SH)
                             : $signed(prod_reg[V_W+FRAC_SH-1:FRAC_SH]);
    assign d_calc = D_W'(v_cur) - D_W'(f_cur);

    assign alpha_sat = (alpha_reg > ALPHA_MAX) ? ALPHA_MAX : alpha_reg;
    assign mul_a     = (state_reg == ST_SCALE) ? D_W'(c_reg) : d_reg;
    assign mul_b     = (state_reg == ST_SCALE) ? GYRO_SCALE : $signed({1'b0, alpha_sat});
    assign prod_calc = P_W'(mul_a) * P_W'(mul_b);
    assign f_upd     = f_cur + prod_reg[FILT_W+FRAC_SH-1:FRAC_SH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ch_reg       <= '0;
            cnt_reg      <= '0;
            cal_done_reg <= 1'b0;
            seeded_reg   <= 1'b0;
            alpha_reg    <= ALPHA_RST;
            gaxis_reg    <= '0;
            gneg_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < CH_N; i++) begin
                sum_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ALPHA: alpha_reg <= cfg_wdata[ALPHA_W-1:0];
                    CFG_GAXIS: gaxis_reg <= cfg_wdata[GAXIS_W-1:0];
                    CFG_GNEG:  gneg_reg  <= cfg_wdata[0];
                    default: ;
                endcase
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        ch_reg    <= '0;
                        state_reg <= cal_done_reg ? ST_CORR : ST_ACC;
                    end
                end
                ST_ACC: begin
                    sum_reg[ch_reg] <= sum_cur + SUM_W'(x_cur);
                    if (ch_reg == CH_LAST) begin
                        cnt_reg <= cnt_next[CNT_W-1:0];
                        ch_reg  <= '0;
                        state_reg <= (cnt_next >= CAL_V) ? ST_DIV_START : ST_IDLE;
                    end else begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end
                ST_DIV_START: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        if (ch_reg == CH_LAST) begin
                            cal_done_reg <= 1'b1;
                            state_reg    <= ST_IDLE;
                        end else begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= ST_DIV_START;
                        end
                    end
                end
                ST_CORR: begin
                    state_reg <= is_accel ? ST_DELTA : ST_SCALE;
                end
                ST_SCALE: begin
                    state_reg <= ST_DELTA;
                end
                ST_DELTA: begin
                    state_reg <= seeded_reg ? ST_MULA : ST_UPD;
                end
                ST_MULA: begin
                    state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    if (ch_reg == CH_LAST) begin
                        seeded_reg <= 1'b1;
                        state_reg  <= ST_EMIT;
                    end else begin
                        ch_reg    <= ch_reg + 1'b1;
                        state_reg <= ST_CORR;
                    end
                end
                ST_EMIT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            for (int i = 0; i < CH_N; i++) begin
                x_reg[i] <= s_tdata[i*RAW_W +: RAW_W];
            end
        end
        if (div_start) begin
            neg_reg <= sum_cur[SUM_W-1];
        end
        if (state_reg == ST_DIV_WAIT && div_done) begin
            bias_reg[ch_reg] <= bias_new;
        end
        if (state_reg == ST_CORR) begin
            c_reg <= c_calc;
        end
        if (state_reg == ST_SCALE || state_reg == ST_MULA) begin
            prod_reg <= prod_calc;
        end
        if (state_reg == ST_DELTA) begin
            v_reg <= v_cur;
            d_reg <= d_calc;
        end
        if (state_reg == ST_UPD) begin
            filt_reg[ch_reg] <= seeded_reg ? f_upd : v_reg[FILT_W-1:0];
        end
        if (out_load) begin
            m_tdata_reg <= {
                {(M_TDATA_W - ACCEL_N*ACC_OUT_W - ACCEL_N*GYR_OUT_W){1'b0}},
                filt_reg[5][GYR_OUT_W-1:0],
                filt_reg[4][GYR_OUT_W-1:0],
                filt_reg[3][GYR_OUT_W-1:0],
                filt_reg[2][ACC_OUT_W-1:0],
                filt_reg[1][ACC_OUT_W-1:0],
                filt_reg[0][ACC_OUT_W-1:0]
            };
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
